/* hw/rtl/tcw_pkg.sv */
// Shared types and constants for the text console writer.
// Depends on nothing; imported by text_console_writer.
package tcw_pkg;

    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;
    localparam int CELLS   = ROWS * COLUMNS;
    localparam int ADDR_W  = $clog2(CELLS);

    // Widths fixed by the item fields.
    localparam int COL_W  = 7;
    localparam int ROW_W  = 5;
    localparam int CELL_W = 16;

    localparam logic [7:0] CH_BACKSPACE = 8'd8;
    localparam logic [7:0] CH_NEWLINE   = 8'd10;
    localparam logic [7:0] CH_SPACE     = 8'd32;

    localparam logic [7:0]        COLOR_RESET = 8'h07;
    localparam logic [CELL_W-1:0] CELL_RESET  = {COLOR_RESET, CH_SPACE};

    localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(CELLS - 1);
    localparam logic [ADDR_W-1:0] COPY_END  = ADDR_W'(CELLS - COLUMNS);
    localparam logic [ADDR_W-1:0] ROW_SPAN  = ADDR_W'(COLUMNS);
    localparam logic [COL_W-1:0]  LAST_COL  = COL_W'(COLUMNS - 1);
    localparam logic [ROW_W-1:0]  LAST_ROW  = ROW_W'(ROWS - 1);

    typedef enum logic [1:0] {
        OP_PUT   = 2'd0,
        OP_CLEAR = 2'd1,
        OP_READ  = 2'd2
    } opcode_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_SCROLL,
        ST_BLANK,
        ST_RESULT
    } state_t;

endpackage

/* hw/rtl/text_console_writer.sv */
// Text console writer: cursor logic around a single screen memory.
// Depends on tcw_pkg for geometry, opcodes and the state type.
//
// Use of the block:
// Requests enter on the s_ stream (opcode in s_tuser, character and read index
// in s_tdata). Every request gives exactly one result on the m_ stream with the
// cursor position after the request, the cell read (read requests only) and a
// scroll flag. The attribute byte for new cells is written on the cfg_ channel,
// which is always ready.
// A character, newline without scroll or backspace touches the screen memory as
// it is accepted; the result is loaded in the result state. A read first passes
// the read state, as the registered memory read must land before the result is
// loaded. The memory has one write and one read port, so a scroll moves one cell
// a cycle: a copy pass moves each row below the top one up a row, then a blank
// pass fills the last row. A clear request writes one cell a cycle over all CELLS
// cells. After reset the block sweeps the memory to blank cells and takes no
// request until then; configuration writes are taken as ever.
// The result sits in an output register, so a new request is taken while the
// previous result waits; a request that finishes while the register is still
// full waits in the result state until the receiver takes the old one.
module text_console_writer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // char_code [7:0], read_index [18:8], zero pad
    input  logic [1:0]  s_tuser,   // opcode [1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // cursor_column [6:0], cursor_line [11:7],
                                   // cell_value [27:12], scrolled [28], zero pad
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data   // text_color
);
    import tcw_pkg::*;

    state_t              state_reg, state_next;
    logic [COL_W-1:0]    col_reg, col_next;
    logic [ROW_W-1:0]    row_reg, row_next;
    logic [ADDR_W-1:0]   scan_reg, scan_next;
    logic [7:0]          color_reg;
    logic [CELL_W-1:0]   fill_reg;
    logic                clr_op_reg;
    logic                pend_valid_reg;
    logic [ADDR_W-1:0]   pend_addr_reg;
    logic                in_range_reg;
    logic [CELL_W-1:0]   cell_reg;
    logic                scrolled_reg;
    logic                out_valid_reg;
    logic [31:0]         out_data_reg;

    logic [CELL_W-1:0]   mem [CELLS];
    logic [CELL_W-1:0]   rd_data_reg;
    logic                mem_we;
    logic [ADDR_W-1:0]   mem_waddr;
    logic [CELL_W-1:0]   mem_wdata;
    logic [ADDR_W-1:0]   mem_raddr;

    opcode_t             opcode;
    logic [7:0]          char_code;
    logic [10:0]         read_index;
    logic                accept;
    logic                is_bs;
    logic                is_nl;
    logic                at_last_col;
    logic                at_last_row;
    logic                need_scroll;
    logic                out_free;
    logic [ADDR_W-1:0]   cur_addr;
    logic [CELL_W-1:0]   blank_cell;

    assign opcode     = opcode_t'(s_tuser);
    assign char_code  = s_tdata[7:0];
    assign read_index = s_tdata[18:8];

    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;
    assign out_free  = !out_valid_reg || m_tready;

    assign is_bs       = (char_code == CH_BACKSPACE);
    assign is_nl       = (char_code == CH_NEWLINE);
    assign at_last_col = (col_reg == LAST_COL);
    assign at_last_row = (row_reg == LAST_ROW);
    assign need_scroll = !is_bs && (is_nl || at_last_col) && at_last_row;
    assign cur_addr    = ADDR_W'(row_reg) * ROW_SPAN + ADDR_W'(col_reg);
    assign blank_cell  = {color_reg, CH_SPACE};

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (scan_reg == LAST_CELL)
                begin
                    state_next = clr_op_reg ? ST_RESULT : ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (opcode)
                        OP_PUT:   state_next = need_scroll ? ST_SCROLL : ST_RESULT;
                        OP_CLEAR: state_next = ST_CLEAR;
                        OP_READ:  state_next = ST_READ;
                        default:  state_next = ST_RESULT;
                    endcase
                end
            end
            ST_READ:   state_next = ST_RESULT;
            ST_SCROLL:
            begin
                if (scan_reg == COPY_END)
                begin
                    state_next = ST_BLANK;
                end
            end
            ST_BLANK:
            begin
                if (scan_reg == LAST_CELL)
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // Memory ports, cursor and sweep counter.
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = cur_addr;
        mem_wdata = blank_cell;
        mem_raddr = ADDR_W'(read_index);
        col_next  = col_reg;
        row_next  = row_reg;
        scan_next = scan_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = scan_reg;
                mem_wdata = fill_reg;
                scan_next = scan_reg + 1'b1;
            end
            ST_IDLE:
            begin
                scan_next = '0;
                if (accept && opcode == OP_PUT)
                begin
                    if (is_bs)
                    begin
                        // The cell before the cursor is always cur_addr - 1,
                        // also when the cursor goes back to the row above.
                        if (cur_addr != '0)
                        begin
                            mem_we    = 1'b1;
                            mem_waddr = cur_addr - 1'b1;
                        end
                        if (col_reg != '0)
                        begin
                            col_next = col_reg - 1'b1;
                        end
                        else if (row_reg != '0)
                        begin
                            col_next = LAST_COL;
                            row_next = row_reg - 1'b1;
                        end
                    end
                    else
                    begin
                        if (!is_nl)
                        begin
                            mem_we    = 1'b1;
                            mem_wdata = {color_reg, char_code};
                        end
                        if (is_nl || at_last_col)
                        begin
                            col_next = '0;
                            if (!at_last_row)
                            begin
                                row_next = row_reg + 1'b1;
                            end
                        end
                        else
                        begin
                            col_next = col_reg + 1'b1;
                        end
                    end
                end
                else if (accept && opcode == OP_CLEAR)
                begin
                    col_next = '0;
                    row_next = '0;
                end
            end
            ST_SCROLL:
            begin
                // Read one row ahead; the cell lands in the next cycle.
                mem_raddr = scan_reg + ROW_SPAN;
                mem_we    = pend_valid_reg;
                mem_waddr = pend_addr_reg;
                mem_wdata = rd_data_reg;
                if (scan_reg != COPY_END)
                begin
                    scan_next = scan_reg + 1'b1;
                end
            end
            ST_BLANK:
            begin
                mem_we    = 1'b1;
                mem_waddr = scan_reg;
                scan_next = scan_reg + 1'b1;
            end
            default:
            begin
                scan_next = scan_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[mem_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            col_reg        <= '0;
            row_reg        <= '0;
            scan_reg       <= '0;
            color_reg      <= COLOR_RESET;
            fill_reg       <= CELL_RESET;
            clr_op_reg     <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            col_reg        <= col_next;
            row_reg        <= row_next;
            scan_reg       <= scan_next;
            pend_valid_reg <= (state_reg == ST_SCROLL) && (scan_reg != COPY_END);
            if (cfg_valid && cfg_ready)
            begin
                color_reg <= cfg_data;
            end
            if (accept && opcode == OP_CLEAR)
            begin
                fill_reg   <= blank_cell;
                clr_op_reg <= 1'b1;
            end
            if (state_reg == ST_RESULT && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pend_addr_reg <= scan_reg;
        if (accept)
        begin
            in_range_reg <= (32'(read_index) < CELLS);
            cell_reg     <= '0;
            scrolled_reg <= (opcode == OP_PUT) && need_scroll;
        end
        if (state_reg == ST_READ)
        begin
            cell_reg <= in_range_reg ? rd_data_reg : '0;
        end
        if (state_reg == ST_RESULT && out_free)
        begin
            out_data_reg <= {3'b000, scrolled_reg, cell_reg, row_reg, col_reg};
        end
    end

endmodule
